// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the queue core rtl
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside of reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/cfq_pkg.sv =====
// shared types, constants and index helpers of the circular queue core
// no dependencies; imported by every module of the block except cfq_ram
`default_nettype none

package cfq_pkg;

	// ring storage
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CAP_W = 5;
	localparam int CNT_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// field widths
	localparam int WORD_W = 32;
	localparam int REQ_W = 2;
	localparam int STAT_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DUMP = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// internal queue depths
	localparam int CQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic signed [WORD_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic signed [WORD_W-1:0] data_out;
		logic last;
	} rsp_t;

	// storage operation for the back end
	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] addr;
		logic signed [WORD_W-1:0] data;
		logic [STAT_W-1:0] status;
		logic last;
	} cmd_t;

	// capacity clamped to 1..DEPTH
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CNT_W-1:0] c;
		c = CNT_W'(cap);
		if (c == '0)
			c = CNT_W'(1);
		else if (c > CNT_W'(DEPTH))
			c = CNT_W'(DEPTH);
		return c;
	endfunction

	// successor index, wrapping at the capacity
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(idx) + CNT_W'(1);
		return (n >= cap) ? '0 : n[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module cfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfq_cmdq.sv =====
// short command queue between the front end and the back end
// depends on cfq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cfq_cmdq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cfq_pkg::cmd_t cmd_in,
	output logic full,
	output logic valid,
	input wire logic pop,
	output cfq_pkg::cmd_t cmd_out
);
	import cfq_pkg::*;

	localparam int PTR_W = $clog2(CQ_DEPTH);
	localparam int CNT_W_Q = PTR_W + 1;

	cmd_t mem_q [CQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W_Q'(CQ_DEPTH));
	assign valid = (count_q != '0);
	assign cmd_out = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= cmd_in;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W_Q'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W_Q'(1);
		end
	end

	// the front end never offers a command the queue cannot take
	`ASSERT_NEVER(a_cmdq_no_overflow, clk, arst_n, push && full, "command pushed while full")
	// a lone transfer out always frees a slot
	`ASSERT_AT(a_cmdq_pop_frees, clk, arst_n, (pop && valid && !push) |=> !full, "pop did not free a slot")

endmodule

`default_nettype wire

// ===== hw/rtl/cfq_front.sv =====
// front end: accepts requests, keeps head, tail and capacity, issues commands
// depends on cfq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cfq_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cfq_pkg::req_t req,
	output logic full,
	input wire logic cfg_we,
	input wire logic [cfq_pkg::CAP_W-1:0] cfg_wdata,
	output logic cmd_push,
	output cfq_pkg::cmd_t cmd,
	input wire logic cmd_full
);
	import cfq_pkg::*;

	typedef enum logic {
		S_RUN,
		S_DUMP
	} state_t;

	state_t state_q;
	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic empty_q;
	logic [IDX_W-1:0] dump_idx_q;
	logic [CNT_W-1:0] dump_k_q;

	logic [CNT_W-1:0] cap_eff;
	logic [IDX_W-1:0] tail_nxt;
	logic [IDX_W-1:0] head_nxt;
	logic [IDX_W-1:0] dump_nxt;
	logic [CNT_W-1:0] dump_k_inc;
	logic dump_fin;
	logic accept;

	assign cap_eff = eff_cap(cap_q);
	assign tail_nxt = next_idx(tail_q, cap_eff);
	assign head_nxt = next_idx(head_q, cap_eff);
	assign dump_nxt = next_idx(dump_idx_q, cap_eff);
	assign dump_k_inc = dump_k_q + CNT_W'(1);
	assign dump_fin = (dump_idx_q == tail_q) || (dump_k_inc >= cap_eff);
	assign full = cmd_full || (state_q == S_DUMP);
	assign accept = push && !full;

	// classify the request and build the command for the back end
	always_comb begin
		cmd_push = 1'b0;
		cmd.op = OP_NONE;
		cmd.addr = '0;
		cmd.data = req.data_in;
		cmd.status = STAT_OK;
		cmd.last = 1'b1;
		case (state_q)
			S_RUN: begin
				if (accept) begin
					case (req.req_type)
						REQ_ENQ: begin
							cmd_push = 1'b1;
							if (empty_q) begin
								cmd.op = OP_WRITE;
							end else if (tail_nxt != head_q) begin
								cmd.op = OP_WRITE;
								cmd.addr = tail_nxt;
							end else begin
								cmd.status = STAT_FULL;
							end
						end
						REQ_DEQ: begin
							cmd_push = 1'b1;
							if (empty_q) begin
								cmd.status = STAT_EMPTY;
							end else begin
								cmd.op = OP_READ;
								cmd.addr = head_q;
							end
						end
						REQ_DUMP: begin
							if (empty_q) begin
								cmd_push = 1'b1;
								cmd.status = STAT_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DUMP: begin
				// one read per held entry, oldest first
				if (!cmd_full) begin
					cmd_push = 1'b1;
					cmd.op = OP_READ;
					cmd.addr = dump_idx_q;
					cmd.last = dump_fin;
				end
			end
			default: begin
			end
		endcase
	end

	// ring indices, capacity register and dump sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			cap_q <= CAP_RESET;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			dump_idx_q <= '0;
			dump_k_q <= '0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			case (state_q)
				S_RUN: begin
					if (accept) begin
						case (req.req_type)
							REQ_ENQ: begin
								if (empty_q) begin
									head_q <= '0;
									tail_q <= '0;
									empty_q <= 1'b0;
								end else if (tail_nxt != head_q) begin
									tail_q <= tail_nxt;
								end
							end
							REQ_DEQ: begin
								if (!empty_q) begin
									if (head_q == tail_q) begin
										empty_q <= 1'b1;
										head_q <= '0;
										tail_q <= '0;
									end else begin
										head_q <= head_nxt;
									end
								end
							end
							REQ_DUMP: begin
								if (!empty_q) begin
									state_q <= S_DUMP;
									dump_idx_q <= head_q;
									dump_k_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DUMP: begin
					if (!cmd_full) begin
						if (dump_fin) begin
							state_q <= S_RUN;
						end else begin
							dump_idx_q <= dump_nxt;
							dump_k_q <= dump_k_inc;
						end
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	// an empty ring always parks both indices at zero
	`ASSERT_AT(a_front_empty_idx, clk, arst_n, empty_q |-> (head_q == '0 && tail_q == '0), "empty ring with nonzero index")
	// a dump only walks a ring that holds words
	`ASSERT_NEVER(a_front_dump_empty, clk, arst_n, (state_q == S_DUMP) && empty_q, "dump of empty ring")

endmodule

`default_nettype wire

// ===== hw/rtl/cfq_back.sv =====
// back end: performs storage writes and reads in order and queues the results
// depends on cfq_pkg, cfq_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cfq_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire cfq_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input wire logic pop,
	output cfq_pkg::rsp_t rsp
);
	import cfq_pkg::*;

	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	logic valid_s1;
	logic is_read_s1;
	logic [STAT_W-1:0] status_s1;
	logic last_s1;
	logic [WORD_W-1:0] rdata;

	rsp_t oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_count_q;
	logic [OQ_CNT_W-1:0] oq_used;
	rsp_t rsp_s1;
	logic oq_pop;

	// take a command only when its result has a guaranteed slot
	assign oq_used = oq_count_q + OQ_CNT_W'(valid_s1);
	assign cmd_pop = cmd_valid && (oq_used < OQ_CNT_W'(OQ_DEPTH));

	// entry storage
	cfq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(cmd_pop && (cmd.op == OP_WRITE)),
		.waddr(cmd.addr),
		.wdata(cmd.data),
		.re(cmd_pop && (cmd.op == OP_READ)),
		.raddr(cmd.addr),
		.rdata(rdata)
	);

	// access stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd_pop;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			is_read_s1 <= (cmd.op == OP_READ);
			status_s1 <= cmd.status;
			last_s1 <= cmd.last;
		end
	end

	// result word, zero unless a stored word was read
	always_comb begin
		rsp_s1.status = status_s1;
		rsp_s1.data_out = is_read_s1 ? rdata : '0;
		rsp_s1.last = last_s1;
	end

	// result queue
	assign empty = (oq_count_q == '0);
	assign rsp = oq_mem_q[oq_rd_q];
	assign oq_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (valid_s1)
			oq_mem_q[oq_wr_q] <= rsp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_count_q <= '0;
		end else begin
			if (valid_s1)
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			if (oq_pop)
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			if (valid_s1 && !oq_pop)
				oq_count_q <= oq_count_q + OQ_CNT_W'(1);
			else if (oq_pop && !valid_s1)
				oq_count_q <= oq_count_q - OQ_CNT_W'(1);
		end
	end

	// the credit check keeps the result queue from overflowing
	`ASSERT_NEVER(a_back_oq_overflow, clk, arst_n, valid_s1 && (oq_count_q == OQ_CNT_W'(OQ_DEPTH)), "result queue overflow")

endmodule

`default_nettype wire

// ===== hw/rtl/circular_fifo_queue_core.sv =====
// top level of the circular queue core: front end, command queue, back end
// depends on cfq_pkg, cfq_front, cfq_cmdq and cfq_back
`default_nettype none

// Ring-buffer queue of signed 32-bit words driven by enqueue, dequeue and dump
// requests, with a queue-style handshake on both sides. Enqueue and dequeue
// requests are taken one per cycle while full is low; a dump of n held words
// (at most the capacity) holds full high while the front end issues one
// storage read per word. An enqueue or dequeue result passes through the
// command queue, the registered storage read and the result queue before it
// shows on the result ports; the first result of a dump comes later, since
// the front end spends the transfer cycle starting the walk. Throughput is
// set by the back end, which takes one command, a write or a read, per cycle
// while the result queue has room. The capacity register must be written only
// while no request is in flight.

module circular_fifo_queue_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cfq_pkg::req_t req,
	output logic full,
	output logic empty,
	input wire logic pop,
	output cfq_pkg::rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [cfq_pkg::CAP_W-1:0] cfg_wdata
);
	import cfq_pkg::*;

	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd_out;

	// request intake and ring bookkeeping
	cfq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.req(req),
		.full(full),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_push(cmd_push),
		.cmd(cmd_in),
		.cmd_full(cmd_full)
	);

	// decoupling queue
	cfq_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.cmd_in(cmd_in),
		.full(cmd_full),
		.valid(cmd_valid),
		.pop(cmd_pop),
		.cmd_out(cmd_out)
	);

	// storage access and result delivery
	cfq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd_out),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

// ===== tb/sv/cfq_checker.sv =====
// result checker for the circular queue core: predicts every result and compares
// depends on cfq_pkg; instantiated by tb_top beside the core
module cfq_checker
	import cfq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire req_t req,
	input wire logic empty,
	input wire logic pop,
	input wire rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [CAP_W-1:0] cfg_wdata,
	output int pending,
	output int errors
);

	// shadow copy of the ring and its pointers
	logic signed [WORD_W-1:0] ring_words [DEPTH];
	logic [IDX_W-1:0] rd_ptr;
	logic [IDX_W-1:0] wr_ptr;
	logic ring_empty;
	logic [CAP_W-1:0] capacity_reg;

	// results still owed by the core, oldest first
	rsp_t expected_rsp [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// capacity clamped to between one and the ring size
	function automatic int ring_span();
		int c;
		c = int'(capacity_reg);
		if (c < 1)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		return c;
	endfunction

	// pointer successor; anything at or past the span wraps to zero
	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p);
		int n;
		n = int'(p) + 1;
		return (n >= ring_span()) ? '0 : IDX_W'(n);
	endfunction

	task automatic owe_result(input logic [STAT_W-1:0] st, input logic signed [WORD_W-1:0] word,
			input logic fin);
		rsp_t r;
		r.status = st;
		r.data_out = word;
		r.last = fin;
		expected_rsp.push_back(r);
	endtask

	// work out the results of one accepted request and update the shadow ring
	task automatic predict_request(input req_t r);
		logic [IDX_W-1:0] nxt;
		logic [IDX_W-1:0] idx;
		int cnt;
		logic fin;
		case (r.req_type)
			REQ_ENQ: begin
				if (ring_empty) begin
					rd_ptr = '0;
					wr_ptr = '0;
					ring_empty = 1'b0;
					ring_words[0] = r.data_in;
					owe_result(STAT_OK, '0, 1'b1);
				end else begin
					nxt = advance(wr_ptr);
					if (nxt == rd_ptr) begin
						owe_result(STAT_FULL, '0, 1'b1);
					end else begin
						wr_ptr = nxt;
						ring_words[wr_ptr] = r.data_in;
						owe_result(STAT_OK, '0, 1'b1);
					end
				end
			end
			REQ_DEQ: begin
				if (ring_empty) begin
					owe_result(STAT_EMPTY, '0, 1'b1);
				end else begin
					owe_result(STAT_OK, ring_words[rd_ptr], 1'b1);
					if (rd_ptr == wr_ptr) begin
						ring_empty = 1'b1;
						rd_ptr = '0;
						wr_ptr = '0;
					end else begin
						rd_ptr = advance(rd_ptr);
					end
				end
			end
			REQ_DUMP: begin
				if (ring_empty) begin
					owe_result(STAT_EMPTY, '0, 1'b1);
				end else begin
					// walk from oldest; a lowered span cuts a runaway walk short
					idx = rd_ptr;
					cnt = 0;
					fin = 1'b0;
					while (!fin) begin
						cnt++;
						fin = (idx == wr_ptr) || (cnt >= ring_span());
						owe_result(STAT_OK, ring_words[idx], fin);
						idx = advance(idx);
					end
				end
			end
			default: ;
		endcase
	endtask

	// compare one transfer out against the oldest owed result
	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			errors++;
			$display("%0t: result with nothing expected: status %0d data %0d last %0d",
				$time, got.status, $signed(got.data_out), got.last);
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, got.status);
			end
			if (got.data_out !== want.data_out) begin
				errors++;
				$display("%0t: data_out mismatch, expected %0d, actual %0d",
					$time, $signed(want.data_out), $signed(got.data_out));
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last mismatch, expected %0d, actual %0d",
					$time, want.last, got.last);
			end
		end
	endtask

	// watch all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_empty = 1'b1;
			rd_ptr = '0;
			wr_ptr = '0;
			capacity_reg = CAP_RESET;
			expected_rsp.delete();
		end else begin
			if (pop && !empty)
				check_result(rsp);
			if (cfg_we)
				capacity_reg = cfg_wdata;
			if (push && !full)
				predict_request(req);
		end
		pending <= expected_rsp.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top for circular_fifo_queue_core: clock, reset, stimulus and verdict
// depends on cfq_pkg, cfq_checker and the core rtl
module tb_top;
	import cfq_pkg::*;

	// request code the core ignores
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic push;
	req_t req;
	logic full;
	logic empty;
	logic pop;
	rsp_t rsp;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	logic idle_on;
	logic hold_req;
	int pending;
	int errors;

	circular_fifo_queue_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.req(req),
		.full(full),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	cfq_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pending(pending),
		.errors(errors)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		logic hold_served;
		pop = 1'b0;
		stall_left = 0;
		hold_left = 0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// one request transfer, then maybe a short gap
	task automatic send_item(input logic [REQ_W-1:0] kind, input logic signed [WORD_W-1:0] word);
		req_t item;
		item.req_type = kind;
		item.data_in = word;
		push <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (full);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed result has been taken
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// capacity write once the core has gone quiet
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// full span and enough dequeues to empty any ring state
	task automatic empty_ring();
		write_capacity(CAP_W'(DEPTH));
		repeat (DEPTH) send_item(REQ_DEQ, $urandom);
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// random requests; ignored codes do not count toward n
	task automatic send_random(input int n, input int enq_pct);
		int sent;
		int r;
		logic [REQ_W-1:0] kind;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < enq_pct)
				kind = REQ_ENQ;
			else if (r < enq_pct + 25)
				kind = REQ_DEQ;
			else if (r < 95)
				kind = REQ_DUMP;
			else
				kind = REQ_UNUSED;
			send_item(kind, pick_word());
			if (kind != REQ_UNUSED)
				sent++;
		end
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps [8];
		push = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases and an ignored code
		send_item(REQ_DEQ, '0);
		send_item(REQ_DUMP, '0);
		send_item(REQ_UNUSED, -32'sd1);

		// fill every entry at full capacity, then overflow and a full dump
		send_item(REQ_ENQ, 32'sh8000_0000);
		send_item(REQ_ENQ, 32'sh7fff_ffff);
		send_item(REQ_ENQ, '0);
		send_item(REQ_ENQ, -32'sd1);
		send_item(REQ_ENQ, 32'sh5555_5555);
		send_item(REQ_ENQ, 32'shaaaa_aaaa);
		repeat (DEPTH - 6) send_item(REQ_ENQ, $urandom);
		send_item(REQ_ENQ, 32'sh1234_5678);
		send_item(REQ_DUMP, '0);

		// shrink the ring while it holds words: runaway dump, tail past the span
		write_capacity(CAP_W'(3));
		send_item(REQ_DUMP, '0);
		send_item(REQ_DEQ, '0);
		send_item(REQ_ENQ, 32'sh0bad_cafe);
		send_item(REQ_DUMP, '0);
		empty_ring();

		// random phases over several capacities, extremes included
		phase_caps = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd0, 5'd16, 5'd0, 5'd8};
		phase_caps[4] = CAP_W'($urandom_range(1, DEPTH));
		phase_caps[6] = CAP_W'($urandom_range(0, 31));
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_caps[p]);
			if (p == 7)
				idle_on <= 1'b0;
			if (p == 5) begin
				// receiver holds off while the sender keeps pushing
				hold_req <= 1'b1;
				send_random(16, 60);
			end else if (p == 3) begin
				send_random(5, 45);
				wait_drained();
				send_random(5, 45);
			end else begin
				send_random(10, 45);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
